/* hw/rtl/fihfo_pkg.sv */
// Shared constants, types and codes for the fade-in/hold/fade-out alpha core.
package fihfo_pkg;

    localparam int TIME_BITS       = 24;
    localparam int ALPHA_FRAC_BITS = 16;
    localparam int DELTA_W         = 16;
    localparam int ELAPSED_W       = TIME_BITS + 1;
    localparam int ALPHA_W         = ALPHA_FRAC_BITS + 1;
    localparam int CNT_W           = $clog2(ALPHA_FRAC_BITS);
    localparam int CFG_IDX_W       = 2;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << ALPHA_FRAC_BITS;

    localparam logic [CFG_IDX_W-1:0] REG_FADE_IN_LEN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_LEN     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_OUT_LEN = 2'd2;

    typedef enum logic [1:0] {
        PH_FADE_IN  = 2'd0,
        PH_HOLD     = 2'd1,
        PH_FADE_OUT = 2'd2,
        PH_DONE     = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_FINISH
    } seq_state_t;

    typedef struct packed {
        logic                 start;
        logic [ELAPSED_W-1:0] num;
        logic [TIME_BITS-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                       done;
        logic [ALPHA_FRAC_BITS-1:0] quot;
    } div_res_t;

endpackage

/* hw/rtl/fihfo_div.sv */
// Iterative restoring divider: floor(num * 2^ALPHA_FRAC_BITS / den), one quotient bit per cycle.
module fihfo_div
(
    input  logic               clk,
    input  logic               rst_n,
    input  fihfo_pkg::div_req_t req,
    output fihfo_pkg::div_res_t res
);

    logic                                  busy_reg;
    logic                                  busy_next;
    logic                                  done_reg;
    logic                                  done_next;
    logic [fihfo_pkg::CNT_W-1:0]           cnt_reg;
    logic [fihfo_pkg::CNT_W-1:0]           cnt_next;
    logic [fihfo_pkg::ELAPSED_W-1:0]       rem_reg;
    logic [fihfo_pkg::ELAPSED_W-1:0]       rem_next;
    logic [fihfo_pkg::TIME_BITS-1:0]       den_reg;
    logic [fihfo_pkg::TIME_BITS-1:0]       den_next;
    logic [fihfo_pkg::ALPHA_FRAC_BITS-1:0] quot_reg;
    logic [fihfo_pkg::ALPHA_FRAC_BITS-1:0] quot_next;

    logic [fihfo_pkg::ELAPSED_W-1:0]       shifted;
    logic [fihfo_pkg::ELAPSED_W:0]         diff;
    logic                                  fits;

    // Remainder stays below den, so the doubled value fits without its top bit.
    assign shifted = {rem_reg[fihfo_pkg::ELAPSED_W-2:0], 1'b0};
    assign diff    = {1'b0, shifted} - {2'b00, den_reg};
    assign fits    = ~diff[fihfo_pkg::ELAPSED_W];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = fihfo_pkg::CNT_W'(fihfo_pkg::ALPHA_FRAC_BITS - 1);
            rem_next  = req.num;
            den_next  = req.den;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[fihfo_pkg::ELAPSED_W-1:0] : shifted;
            quot_next = {quot_reg[fihfo_pkg::ALPHA_FRAC_BITS-2:0], fits};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign res.done = done_reg;
    assign res.quot = quot_reg;

endmodule

/* hw/rtl/fade_in_hold_fade_out_alpha_core.sv */
// Top level: phase sequencer, length registers and result register around the shared divider.
// A tick taken in idle goes to check, then to the divider if its phase needs a ratio, then to finish;
// check hands each spent phase over to the next, and finish waits until the output register is free.
// Ticks that end in hold or done skip the divider.
// tick_stall is high until the result is in the output register, so one tick is handled at a time.
// Reset (rst_n, asynchronous, active low) clears lengths, phase, elapsed time and alpha.
module fade_in_hold_fade_out_alpha_core
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [fihfo_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fihfo_pkg::TIME_BITS-1:0]       cfg_data,
    input  logic                                  tick_valid,
    output logic                                  tick_stall,
    input  logic [fihfo_pkg::DELTA_W-1:0]         tick_delta,
    output logic                                  res_valid,
    input  logic                                  res_stall,
    output logic [fihfo_pkg::ALPHA_W-1:0]         alpha_level,
    output logic [1:0]                            phase_now,
    output logic                                  done_res
);

    fihfo_pkg::seq_state_t                 state_reg;
    fihfo_pkg::seq_state_t                 state_next;
    fihfo_pkg::phase_t                     phase_reg;
    fihfo_pkg::phase_t                     phase_next;
    logic [fihfo_pkg::ELAPSED_W-1:0]       elapsed_reg;
    logic [fihfo_pkg::ELAPSED_W-1:0]       elapsed_next;
    logic [fihfo_pkg::ALPHA_W-1:0]         alpha_reg;
    logic [fihfo_pkg::ALPHA_W-1:0]         alpha_next;
    logic [fihfo_pkg::DELTA_W-1:0]         delta_reg;
    logic [fihfo_pkg::DELTA_W-1:0]         delta_next;
    logic [fihfo_pkg::TIME_BITS-1:0]       fade_in_len_reg;
    logic [fihfo_pkg::TIME_BITS-1:0]       hold_len_reg;
    logic [fihfo_pkg::TIME_BITS-1:0]       fade_out_len_reg;
    logic                                  res_valid_reg;
    logic                                  res_valid_next;
    logic [fihfo_pkg::ALPHA_W-1:0]         alpha_out_reg;
    logic [fihfo_pkg::ALPHA_W-1:0]         alpha_out_next;
    logic [1:0]                            phase_out_reg;
    logic [1:0]                            phase_out_next;

    fihfo_pkg::div_req_t                   div_req;
    fihfo_pkg::div_res_t                   div_res;

    logic [fihfo_pkg::ELAPSED_W-1:0]       elapsed_adv;
    logic                                  in_fade_in;
    logic                                  in_hold;
    logic                                  in_fade_out;
    logic                                  tick_take;
    logic                                  res_free;

    assign cfg_ready   = 1'b1;
    assign tick_stall  = (state_reg != fihfo_pkg::ST_IDLE);
    assign tick_take   = tick_valid && !tick_stall;
    assign res_free    = !res_valid_reg || !res_stall;

    assign elapsed_adv = elapsed_reg + fihfo_pkg::ELAPSED_W'(delta_reg);
    assign in_fade_in  = elapsed_reg < {1'b0, fade_in_len_reg};
    assign in_hold     = (hold_len_reg != '0) && (elapsed_reg < {1'b0, hold_len_reg});
    assign in_fade_out = (fade_out_len_reg != '0) && (elapsed_reg < {1'b0, fade_out_len_reg});

    fihfo_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .res   (div_res)
    );

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        elapsed_next   = elapsed_reg;
        alpha_next     = alpha_reg;
        delta_next     = delta_reg;
        res_valid_next = res_valid_reg && res_stall;
        alpha_out_next = alpha_out_reg;
        phase_out_next = phase_out_reg;
        div_req.start  = 1'b0;
        div_req.num    = elapsed_reg;
        div_req.den    = (phase_reg == fihfo_pkg::PH_FADE_IN) ? fade_in_len_reg
                                                               : fade_out_len_reg;
        case (state_reg)
            fihfo_pkg::ST_IDLE:
            begin
                if (tick_take)
                begin
                    delta_next = tick_delta;
                    state_next = fihfo_pkg::ST_CHECK;
                end
            end
            fihfo_pkg::ST_CHECK:
            begin
                // Check one phase per cycle; a spent phase hands over to the next.
                case (phase_reg)
                    fihfo_pkg::PH_FADE_IN:
                    begin
                        if (in_fade_in)
                        begin
                            div_req.start = 1'b1;
                            state_next    = fihfo_pkg::ST_DIV;
                        end
                        else
                        begin
                            phase_next   = fihfo_pkg::PH_HOLD;
                            elapsed_next = '0;
                        end
                    end
                    fihfo_pkg::PH_HOLD:
                    begin
                        if (in_hold)
                        begin
                            alpha_next   = fihfo_pkg::ALPHA_ONE;
                            elapsed_next = elapsed_adv;
                            state_next   = fihfo_pkg::ST_FINISH;
                        end
                        else
                        begin
                            phase_next   = fihfo_pkg::PH_FADE_OUT;
                            elapsed_next = '0;
                        end
                    end
                    fihfo_pkg::PH_FADE_OUT:
                    begin
                        if (in_fade_out)
                        begin
                            div_req.start = 1'b1;
                            state_next    = fihfo_pkg::ST_DIV;
                        end
                        else
                        begin
                            phase_next = fihfo_pkg::PH_DONE;
                            state_next = fihfo_pkg::ST_FINISH;
                        end
                    end
                    default:
                    begin
                        state_next = fihfo_pkg::ST_FINISH;
                    end
                endcase
            end
            fihfo_pkg::ST_DIV:
            begin
                if (div_res.done)
                begin
                    if (phase_reg == fihfo_pkg::PH_FADE_IN)
                    begin
                        alpha_next = {1'b0, div_res.quot};
                    end
                    else
                    begin
                        alpha_next = fihfo_pkg::ALPHA_ONE - {1'b0, div_res.quot};
                    end
                    elapsed_next = elapsed_adv;
                    state_next   = fihfo_pkg::ST_FINISH;
                end
            end
            fihfo_pkg::ST_FINISH:
            begin
                // Hold the result until the output register is free.
                if (res_free)
                begin
                    res_valid_next = 1'b1;
                    alpha_out_next = alpha_reg;
                    phase_out_next = phase_reg;
                    state_next     = fihfo_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fihfo_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= fihfo_pkg::ST_IDLE;
            phase_reg        <= fihfo_pkg::PH_FADE_IN;
            elapsed_reg      <= '0;
            alpha_reg        <= '0;
            res_valid_reg    <= 1'b0;
            fade_in_len_reg  <= '0;
            hold_len_reg     <= '0;
            fade_out_len_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            elapsed_reg   <= elapsed_next;
            alpha_reg     <= alpha_next;
            res_valid_reg <= res_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    fihfo_pkg::REG_FADE_IN_LEN:  fade_in_len_reg  <= cfg_data;
                    fihfo_pkg::REG_HOLD_LEN:     hold_len_reg     <= cfg_data;
                    fihfo_pkg::REG_FADE_OUT_LEN: fade_out_len_reg <= cfg_data;
                    default:                     ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        delta_reg     <= delta_next;
        alpha_out_reg <= alpha_out_next;
        phase_out_reg <= phase_out_next;
    end

    assign res_valid   = res_valid_reg;
    assign alpha_level = alpha_out_reg;
    assign phase_now   = phase_out_reg;
    assign done_res    = (phase_out_reg == fihfo_pkg::PH_DONE);

endmodule
